// ===== rtl/weighted_random_index_sampler_defines.svh =====
// ----------------------------------------------------------------------------
// Weighted random index sampler: assertion macros
// Wrappers for concurrent checks; they expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_INDEX_SAMPLER_DEFINES_SVH
`define WEIGHTED_RANDOM_INDEX_SAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WRIS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("weighted_random_index_sampler: check failed");
// next-cycle implication
`define WRIS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("weighted_random_index_sampler: check failed");
`else
`define WRIS_ASSERT_IMP(label, clk, rst, ante, cons)
`define WRIS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/wris_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted random index sampler: package
// Shared codes, state encoding and generator constants.
// ----------------------------------------------------------------------------
package wris_pkg;

  // fixed field widths of the ports
  localparam int INDEX_W     = 6;
  localparam int WEIGHT_IN_W = 16;
  localparam int COUNT_W     = 7;
  localparam int SEED_W      = 64;
  localparam int PICK_W      = 6;
  localparam int CFG_INDEX_W = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SEED        = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 1'b1;

  localparam logic [SEED_W-1:0]  SEED_RESET  = 64'd42;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  // splitmix64 constants
  localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

  // fraction has 53 bits
  localparam int FRAC_W = 53;

  // command queue depth (power of two)
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX1,
    ST_FOLD1,
    ST_MIX2,
    ST_FOLD2,
    ST_SCALE,
    ST_TARGET,
    ST_SEARCH
  } state_t;

endpackage

// ===== rtl/weighted_random_index_sampler.sv =====
// ----------------------------------------------------------------------------
// Weighted random index sampler: top level
// Draws table indices with probability proportional to loaded weights.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: start, mode, entry_index, entry_weight. A command
//   transfer happens on a clock edge with start high and busy low.
//   mode 0 loads a weight (entry 0 restarts the running sum, loads go in
//   index order); mode 1 draws an index.
//   Result channel: done pulses for one cycle with picked_index; there is
//   no back-pressure, every pulse is one result.
//   Config port: cfg_we, cfg_index, cfg_data. Index 0 writes the seed and
//   reloads the generator, index 1 writes entry_count. Write only when idle.
// Back end:
//   A load is retired without leaving idle. A draw steps through MIX1, FOLD1,
//   MIX2, FOLD2, SCALE and TARGET, then makes P table probes in SEARCH, P at
//   most ceil(log2(n+1)) (up to 7 for 64 entries), one probe per cycle.
//   done is registered from the last probe of the search.
//   A two-entry queue sits between front and back, so busy only rises when
//   commands arrive faster than the back end retires them.
// Reset: rst (sync, active high) empties the queue, clears the running sum,
//   sets seed 42 and entry_count 64; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "weighted_random_index_sampler_defines.svh"

module weighted_random_index_sampler #(
  parameter int MAX_ENTRIES = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  mode,
  input  logic [wris_pkg::INDEX_W-1:0]          entry_index,
  input  logic [wris_pkg::WEIGHT_IN_W-1:0]      entry_weight,
  // result channel
  output logic                                  done,
  output logic [wris_pkg::PICK_W-1:0]           picked_index,
  // config port
  input  logic                                  cfg_we,
  input  logic [wris_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wris_pkg::SEED_W-1:0]           cfg_data
);

  logic [wris_pkg::COUNT_W-1:0]   entry_count;
  logic                           seed_load;

  // queue between front and back
  logic                           q_valid;
  logic                           q_pop;
  wris_pkg::op_t                  q_op;
  logic [$clog2(MAX_ENTRIES)-1:0] q_index;
  logic [WEIGHT_BITS-1:0]         q_weight;

  // seed lives only as generator state: a write reloads it directly
  assign seed_load = cfg_we && (cfg_index == wris_pkg::REG_SEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= wris_pkg::COUNT_RESET;
    end else if (cfg_we && (cfg_index == wris_pkg::REG_ENTRY_COUNT)) begin
      entry_count <= cfg_data[wris_pkg::COUNT_W-1:0];
    end
  end

  // front: take commands, filter out-of-table loads, queue
  wris_front #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .entry_index  (entry_index),
    .entry_weight (entry_weight),
    .busy         (busy),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_index      (q_index),
    .q_weight     (q_weight),
    .q_pop        (q_pop)
  );

  // back: table writes, generator, scaling and search
  wris_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .entry_count  (entry_count),
    .seed_load    (seed_load),
    .seed_value   (cfg_data),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_index      (q_index),
    .q_weight     (q_weight),
    .q_pop        (q_pop),
    .done         (done),
    .picked_index (picked_index)
  );

  // a full queue always offers an item to the back end
  `WRIS_ASSERT_IMP(a_full_has_item, clk, rst, busy, q_valid)
  // back end never pops an empty queue
  `WRIS_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, q_valid)
  // a draw runs through the mixer and search states, so results never come in adjacent cycles
  `WRIS_ASSERT_NXT(a_done_single, clk, rst, done, !done)
  // the back end is busy with the draw search while the result is built
  `WRIS_ASSERT_IMP(a_no_pop_on_done, clk, rst, done, !$past(q_pop))

endmodule

// ===== rtl/wris_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wris_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wris_front.sv =====
// ----------------------------------------------------------------------------
// Weighted random index sampler: front end
// Takes commands, drops out-of-range loads, queues the rest for the back end.
// ----------------------------------------------------------------------------
module wris_front #(
  parameter int MAX_ENTRIES = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                mode,
  input  logic [wris_pkg::INDEX_W-1:0]        entry_index,
  input  logic [wris_pkg::WEIGHT_IN_W-1:0]    entry_weight,
  output logic                                busy,
  output logic                                q_valid,
  output wris_pkg::op_t                       q_op,
  output logic [$clog2(MAX_ENTRIES)-1:0]      q_index,
  output logic [WEIGHT_BITS-1:0]              q_weight,
  input  logic                                q_pop
);

  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int QD      = wris_pkg::QUEUE_DEPTH;
  localparam int PTR_W   = $clog2(QD);
  localparam int QCNT_W  = $clog2(QD + 1);
  localparam int IEXT_W  = IDX_W + wris_pkg::INDEX_W;
  localparam int WEXT_W  = WEIGHT_BITS + wris_pkg::WEIGHT_IN_W;

  wris_pkg::op_t        op_mem  [QD];
  logic [IDX_W-1:0]     idx_mem [QD];
  logic [WEIGHT_BITS-1:0] w_mem [QD];

  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] count;

  logic              accept;
  logic              push;
  logic              in_range;
  wris_pkg::op_t     in_op;
  logic [IEXT_W-1:0] idx_ext;
  logic [WEXT_W-1:0] w_ext;

  assign busy    = (count == QCNT_W'(QD));
  assign q_valid = (count != '0);
  assign accept  = start && !busy;

  // classify: draws always go through, loads only inside the table
  assign in_op    = wris_pkg::op_t'(mode);
  assign idx_ext  = {{IDX_W{1'b0}}, entry_index};
  assign w_ext    = {{WEIGHT_BITS{1'b0}}, entry_weight};
  assign in_range = (idx_ext < IEXT_W'(MAX_ENTRIES));
  assign push     = accept && ((in_op == wris_pkg::OP_DRAW) || in_range);

  assign q_op     = op_mem[rd_ptr];
  assign q_index  = idx_mem[rd_ptr];
  assign q_weight = w_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      op_mem[wr_ptr]  <= in_op;
      idx_mem[wr_ptr] <= idx_ext[IDX_W-1:0];
      w_mem[wr_ptr]   <= w_ext[WEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + QCNT_W'(1);
      end else if (q_pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/wris_back.sv =====
// ----------------------------------------------------------------------------
// Weighted random index sampler: back end
// Executes loads into the cumulative table and runs the draw sequence.
// ----------------------------------------------------------------------------
module wris_back #(
  parameter int MAX_ENTRIES = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [wris_pkg::COUNT_W-1:0]     entry_count,
  input  logic                             seed_load,
  input  logic [wris_pkg::SEED_W-1:0]      seed_value,
  input  logic                             q_valid,
  input  wris_pkg::op_t                    q_op,
  input  logic [$clog2(MAX_ENTRIES)-1:0]   q_index,
  input  logic [WEIGHT_BITS-1:0]           q_weight,
  output logic                             q_pop,
  output logic                             done,
  output logic [wris_pkg::PICK_W-1:0]      picked_index
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int SUM_W  = WEIGHT_BITS + IDX_W;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > wris_pkg::COUNT_W) ? CNT_W : wris_pkg::COUNT_W;
  localparam int FRAC_W = wris_pkg::FRAC_W;
  localparam int PEXT_W = CNT_W + wris_pkg::PICK_W;

  wris_pkg::state_t state;
  wris_pkg::state_t state_next;

  logic [63:0]       gen;
  logic [63:0]       x;
  logic [FRAC_W-1:0] frac;
  logic [SUM_W-1:0]  total;
  logic [SUM_W-1:0]  target;
  logic [SUM_W-1:0]  running_total;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  len;
  logic [IDX_W-1:0]  mid;
  logic [63:0]       pp00, pp01, pp10, pp11;

  // effective entry count
  logic [CMP_W-1:0]  cnt_ext;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  n_m1;
  logic [CNT_W-1:0]  n_half;

  // load path
  logic              do_load;
  logic              do_draw;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [SUM_W-1:0]  w_ext;

  // generator and multiplier
  logic [63:0]       gen_adv;
  logic [63:0]       op_a, op_b;
  logic [63:0]       mix_sum;
  logic [63:0]       mix_out;
  logic [127:0]      full_prod;

  // search
  logic [IDX_W-1:0]  raddr;
  logic [SUM_W-1:0]  rdata;
  logic [CNT_W-1:0]  half;
  logic              le;
  logic [CNT_W-1:0]  lo_next;
  logic [CNT_W-1:0]  len_next;
  logic [CNT_W-1:0]  mid_next;
  logic [CNT_W-1:0]  pick;
  logic [PEXT_W-1:0] pick_ext;
  logic              finish;

  assign cnt_ext = CMP_W'(entry_count);
  always_comb begin
    if (entry_count == '0) begin
      n = CNT_W'(1);
    end else if (cnt_ext > CMP_W'(MAX_ENTRIES)) begin
      n = CNT_W'(MAX_ENTRIES);
    end else begin
      n = cnt_ext[CNT_W-1:0];
    end
  end
  assign n_m1   = n - CNT_W'(1);
  assign n_half = n >> 1;

  assign q_pop   = (state == wris_pkg::ST_IDLE) && q_valid;
  assign do_load = q_pop && (q_op == wris_pkg::OP_LOAD);
  assign do_draw = q_pop && (q_op == wris_pkg::OP_DRAW);

  // running sum, saturating
  assign w_ext = SUM_W'(q_weight);
  always_comb begin
    if (q_index == '0) begin
      sum_ext = {1'b0, w_ext};
    end else begin
      sum_ext = {1'b0, running_total} + {1'b0, w_ext};
    end
    sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  end

  assign gen_adv = gen + wris_pkg::GOLDEN_STEP;

  // shared 32x32 partial-product unit operands
  always_comb begin
    case (state)
      wris_pkg::ST_MIX2: begin
        op_a = x;
        op_b = wris_pkg::MIX_MUL_B;
      end
      wris_pkg::ST_SCALE: begin
        op_a = 64'(frac);
        op_b = 64'(total);
      end
      default: begin
        op_a = x;
        op_b = wris_pkg::MIX_MUL_A;
      end
    endcase
  end

  assign mix_sum   = pp00 + {pp01[31:0], 32'b0} + {pp10[31:0], 32'b0};
  assign mix_out   = mix_sum ^ (mix_sum >> 31);
  assign full_prod = {64'b0, pp00} + {32'b0, pp01, 32'b0} + {32'b0, pp10, 32'b0}
                   + {pp11, 64'b0};

  // one probe per cycle: rdata belongs to mid
  assign half     = len >> 1;
  assign le       = (rdata <= target);
  assign lo_next  = le ? (CNT_W'(mid) + CNT_W'(1)) : lo;
  assign len_next = le ? (len - half - CNT_W'(1)) : half;
  assign mid_next = lo_next + (len_next >> 1);
  assign finish   = (state == wris_pkg::ST_SEARCH) && (len_next == '0);
  assign pick     = (lo_next >= n) ? n_m1 : lo_next;
  assign pick_ext = {{wris_pkg::PICK_W{1'b0}}, pick};

  always_comb begin
    case (state)
      wris_pkg::ST_TARGET: raddr = n_half[IDX_W-1:0];
      wris_pkg::ST_SEARCH: raddr = mid_next[IDX_W-1:0];
      default:             raddr = n_m1[IDX_W-1:0];
    endcase
  end

  wris_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (do_load),
    .waddr (q_index),
    .wdata (sum_sat),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      wris_pkg::ST_IDLE:   if (do_draw) state_next = wris_pkg::ST_MIX1;
      wris_pkg::ST_MIX1:   state_next = wris_pkg::ST_FOLD1;
      wris_pkg::ST_FOLD1:  state_next = wris_pkg::ST_MIX2;
      wris_pkg::ST_MIX2:   state_next = wris_pkg::ST_FOLD2;
      wris_pkg::ST_FOLD2:  state_next = wris_pkg::ST_SCALE;
      wris_pkg::ST_SCALE:  state_next = wris_pkg::ST_TARGET;
      wris_pkg::ST_TARGET: state_next = wris_pkg::ST_SEARCH;
      wris_pkg::ST_SEARCH: if (finish) state_next = wris_pkg::ST_IDLE;
      default:             state_next = wris_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wris_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      gen           <= wris_pkg::SEED_RESET;
      running_total <= '0;
      done          <= 1'b0;
    end else begin
      done <= finish;
      if (seed_load) begin
        gen <= seed_value;
      end else if (do_draw) begin
        gen <= gen_adv;
      end
      if (do_load) begin
        running_total <= sum_sat;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    pp00 <= 64'(op_a[31:0])  * 64'(op_b[31:0]);
    pp01 <= 64'(op_a[31:0])  * 64'(op_b[63:32]);
    pp10 <= 64'(op_a[63:32]) * 64'(op_b[31:0]);
    pp11 <= 64'(op_a[63:32]) * 64'(op_b[63:32]);
    case (state)
      wris_pkg::ST_IDLE: begin
        x <= gen_adv ^ (gen_adv >> 30);
      end
      wris_pkg::ST_MIX1: begin
        total <= rdata;
      end
      wris_pkg::ST_FOLD1: begin
        x <= mix_sum ^ (mix_sum >> 27);
      end
      wris_pkg::ST_FOLD2: begin
        frac <= mix_out[63:64-FRAC_W];
      end
      wris_pkg::ST_TARGET: begin
        target <= full_prod[FRAC_W +: SUM_W];
        lo     <= '0;
        len    <= n;
        mid    <= n_half[IDX_W-1:0];
      end
      wris_pkg::ST_SEARCH: begin
        lo  <= lo_next;
        len <= len_next;
        mid <= mid_next[IDX_W-1:0];
        if (finish) begin
          picked_index <= pick_ext[wris_pkg::PICK_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted random index sampler: testbench
// Drives load and draw commands in random bursts, predicts each picked index
// with an in-bench splitmix64 generator and upper-bound table search, and
// checks every done pulse against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb;

  localparam int          NUM_ENTRIES   = 64;
  localparam int          SUM_W         = 22;           // 16 weight bits + log2(64)
  localparam int          PROD_W        = wris_pkg::FRAC_W + SUM_W;
  localparam logic [SUM_W-1:0] SUM_CAP  = '1;
  localparam int          RANDOM_ITEMS  = 800;
  localparam int          SETTLE_CYCLES = 40;           // queued loads + one full draw
  localparam int unsigned CYCLE_LIMIT   = 300000;

  // one command transfer
  typedef struct packed {
    wris_pkg::op_t                    op;
    logic [wris_pkg::INDEX_W-1:0]     idx;
    logic [wris_pkg::WEIGHT_IN_W-1:0] weight;
  } cmd_t;

  // one predicted pick, tagged with the draw it belongs to
  typedef struct {
    logic [wris_pkg::PICK_W-1:0] pick;
    int unsigned                 draw_no;
  } pick_t;

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             start        = 1'b0;
  logic                             busy;
  logic                             mode         = 1'b0;
  logic [wris_pkg::INDEX_W-1:0]     entry_index  = '0;
  logic [wris_pkg::WEIGHT_IN_W-1:0] entry_weight = '0;
  logic                             done;
  logic [wris_pkg::PICK_W-1:0]      picked_index;
  logic                             cfg_we       = 1'b0;
  logic [wris_pkg::CFG_INDEX_W-1:0] cfg_index    = wris_pkg::REG_SEED;
  logic [wris_pkg::SEED_W-1:0]      cfg_data     = '0;

  weighted_random_index_sampler uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .entry_index  (entry_index),
    .entry_weight (entry_weight),
    .done         (done),
    .picked_index (picked_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction state: generator, entry count, cumulative table, running sum
  // --------------------------------------------------------------------------
  logic [63:0]                  gen_state;
  logic [wris_pkg::COUNT_W-1:0] count_reg;
  logic [SUM_W-1:0]             cum_table [NUM_ENTRIES];
  logic [SUM_W-1:0]             run_sum;

  pick_t       expected_picks [$];
  cmd_t        pending_cmds [$];
  cmd_t        cur_cmd;
  int unsigned cmds_issued = 0;
  int unsigned cmds_taken  = 0;
  int unsigned loads_seen  = 0;
  int unsigned draws_seen  = 0;
  int unsigned cfg_writes  = 0;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  bit          picks_hit [NUM_ENTRIES];

  // stimulus-side bookkeeping: which entries hold a defined sum, live count
  bit          tbl_loaded [NUM_ENTRIES];
  int unsigned gen_n;

  // splitmix64 output mix
  function automatic logic [63:0] splitmix_mix(logic [63:0] z);
    z = (z ^ (z >> 30)) * wris_pkg::MIX_MUL_A;
    z = (z ^ (z >> 27)) * wris_pkg::MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  // 0 acts as one entry, anything past the table acts as the full table
  function automatic int unsigned live_entries(logic [wris_pkg::COUNT_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > NUM_ENTRIES) return NUM_ENTRIES;
    return 32'(cnt);
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Apply one accepted command to the prediction state. A load updates the
  // running sum (restarted by entry 0, saturating at the sum width) and stores
  // it; a draw steps the generator, scales the 53-bit fraction by the last
  // live entry and runs the upper-bound search over the live entries.
  task automatic predict_transfer(cmd_t c);
    logic [SUM_W:0]              sum;
    logic [wris_pkg::FRAC_W-1:0] frac;
    logic [PROD_W-1:0]           prod;
    logic [SUM_W-1:0]            target;
    int unsigned                 n, lo, len, half, mid;
    pick_t                       np;
    if (c.op == wris_pkg::OP_LOAD) begin
      sum = (c.idx == '0) ? (SUM_W+1)'(c.weight)
                          : (SUM_W+1)'(run_sum) + (SUM_W+1)'(c.weight);
      if (sum > {1'b0, SUM_CAP}) sum = {1'b0, SUM_CAP};
      run_sum = sum[SUM_W-1:0];
      cum_table[c.idx] = sum[SUM_W-1:0];
      loads_seen++;
    end else begin
      n = live_entries(count_reg);
      gen_state = gen_state + wris_pkg::GOLDEN_STEP;
      frac = wris_pkg::FRAC_W'(splitmix_mix(gen_state) >> (64 - wris_pkg::FRAC_W));
      prod = PROD_W'(frac) * PROD_W'(cum_table[n-1]);
      target = SUM_W'(prod >> wris_pkg::FRAC_W);
      lo = 0;
      len = n;
      while (len > 0) begin
        half = len >> 1;
        mid = lo + half;
        if (cum_table[mid] <= target) begin
          lo = mid + 1;
          len = len - half - 1;
        end else begin
          len = half;
        end
      end
      if (lo >= n) lo = n - 1;
      np.pick    = wris_pkg::PICK_W'(lo);
      np.draw_no = draws_seen;
      expected_picks.insert(expected_picks.size(), np);
      draws_seen++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps, fed from pending_cmds
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // transfer at this edge: start was high and the block was not busy
      if (start && !busy) begin
        predict_transfer(cur_cmd);
        cmds_taken++;
      end
      if (start && busy) begin
        // block is holding off; keep the same command on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        start        <= 1'b1;
        mode         <= cur_cmd.op;
        entry_index  <= cur_cmd.idx;
        entry_weight <= cur_cmd.weight;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // new burst; about a quarter of them run straight on with no gap
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every done pulse is a result; compare with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pick_t exp_pick;
    if (!rst && done) begin
      if (expected_picks.size() == 0) begin
        flag_mismatch($sformatf("result with no draw pending, picked_index %0d",
                                picked_index));
      end else begin
        exp_pick = expected_picks.pop_front();
        if (picked_index !== exp_pick.pick)
          flag_mismatch($sformatf("draw %0d: picked_index %0d, expected %0d",
                                  exp_pick.draw_no, picked_index, exp_pick.pick));
        else
          picks_hit[exp_pick.pick] = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d draws still pending",
               cycle_count, expected_picks.size());
      $display("weighted_random_index_sampler test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_load(int unsigned idx, logic [wris_pkg::WEIGHT_IN_W-1:0] w);
    cmd_t c;
    c.op     = wris_pkg::OP_LOAD;
    c.idx    = wris_pkg::INDEX_W'(idx);
    c.weight = w;
    pending_cmds.insert(pending_cmds.size(), c);
    tbl_loaded[idx] = 1'b1;
    cmds_issued++;
  endtask

  // A draw can probe any live entry, so it is only queued once all of them
  // hold a defined sum. Index and weight are don't-care on a draw.
  task automatic queue_draw();
    cmd_t c;
    for (int i = 0; i < gen_n; i++)
      if (!tbl_loaded[i]) return;
    c.op     = wris_pkg::OP_DRAW;
    c.idx    = wris_pkg::INDEX_W'($urandom);
    c.weight = wris_pkg::WEIGHT_IN_W'($urandom);
    pending_cmds.insert(pending_cmds.size(), c);
    cmds_issued++;
  endtask

  function automatic logic [wris_pkg::WEIGHT_IN_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return wris_pkg::WEIGHT_IN_W'($urandom_range(1, 15));
      default: return wris_pkg::WEIGHT_IN_W'($urandom);
    endcase
  endfunction

  function automatic logic [wris_pkg::SEED_W-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Entry count: mostly small tables, sometimes the full one, and now and
  // then 0 or past the table end. Bits above the register are sometimes junk.
  function automatic logic [wris_pkg::SEED_W-1:0] pick_count();
    logic [wris_pkg::SEED_W-1:0] v;
    v = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : '0;
    case ($urandom_range(0, 9))
      0:       v[wris_pkg::COUNT_W-1:0] = '0;
      1:       v[wris_pkg::COUNT_W-1:0] = wris_pkg::COUNT_W'($urandom_range(65, 127));
      2:       v[wris_pkg::COUNT_W-1:0] = wris_pkg::COUNT_W'(NUM_ENTRIES);
      3:       v[wris_pkg::COUNT_W-1:0] = wris_pkg::COUNT_W'($urandom_range(1, NUM_ENTRIES));
      default: v[wris_pkg::COUNT_W-1:0] = wris_pkg::COUNT_W'($urandom_range(1, 8));
    endcase
    return v;
  endfunction

  // register write; only called with the block idle, so the prediction
  // state can follow right away
  task automatic write_reg(logic [wris_pkg::CFG_INDEX_W-1:0] which,
                           logic [wris_pkg::SEED_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == wris_pkg::REG_SEED) begin
      gen_state = val;
    end else begin
      count_reg = val[wris_pkg::COUNT_W-1:0];
      gen_n = live_entries(val[wris_pkg::COUNT_W-1:0]);
    end
    cfg_writes++;
  endtask

  // Hold the sender until every queued command has transferred and every
  // predicted pick has come back, then let trailing loads drain.
  task automatic settle();
    do @(negedge clk);
    while (cmds_taken != cmds_issued || expected_picks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned directed_items, phase_no, kind, hit_cnt, reload_to;
    gen_state = wris_pkg::SEED_RESET;
    count_reg = wris_pkg::COUNT_RESET;
    run_sum   = '0;
    gen_n     = live_entries(wris_pkg::COUNT_RESET);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The reset seed is left in place for the first draws.
    // Four entries: max weight, zero weight, min weight, mixed bits.
    write_reg(wris_pkg::REG_ENTRY_COUNT, 64'd4);
    queue_load(0, '1);
    queue_load(1, '0);
    queue_load(2, 16'd1);
    queue_load(3, 16'hAAAA);
    repeat (4) queue_draw();
    // rewriting entry 2 alone leaves the sums out of order
    queue_load(2, 16'h5555);
    // top entry index; outside the live range so it is never probed
    queue_load(NUM_ENTRIES - 1, '1);
    repeat (3) queue_draw();
    settle();
    // zero seed, and a zero count that behaves as a single entry
    write_reg(wris_pkg::REG_SEED, '0);
    write_reg(wris_pkg::REG_ENTRY_COUNT, 64'd0);
    repeat (2) queue_draw();
    settle();
    // all-ones seed over two entries
    write_reg(wris_pkg::REG_SEED, '1);
    write_reg(wris_pkg::REG_ENTRY_COUNT, 64'd2);
    repeat (3) queue_draw();
    settle();
    directed_items = cmds_issued;

    // Full table once, with a count past the end that clamps to 64.
    write_reg(wris_pkg::REG_ENTRY_COUNT, 64'd127);
    for (int i = 0; i < NUM_ENTRIES; i++) queue_load(i, rand_weight());
    repeat (6) queue_draw();

    // Random phases. Config only changes between phases, with the block idle.
    phase_no = 0;
    while (cmds_issued < directed_items + RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 2) == 0) write_reg(wris_pkg::REG_SEED, pick_seed());
      if ($urandom_range(0, 1) == 0) write_reg(wris_pkg::REG_ENTRY_COUNT, pick_count());
      kind = (phase_no == 2) ? 10 : $urandom_range(0, 9);
      if (kind <= 6) begin
        // well-formed: load the live entries in order, then draw; sometimes
        // reload a prefix, which restarts the sum at entry 0
        for (int i = 0; i < gen_n; i++) queue_load(i, rand_weight());
        repeat ($urandom_range(2, 12)) queue_draw();
        if ($urandom_range(0, 1) == 0) begin
          reload_to = $urandom_range(0, gen_n - 1);
          for (int i = 0; i <= reload_to; i++) queue_load(i, rand_weight());
          repeat ($urandom_range(1, 4)) queue_draw();
        end
      end else if (kind <= 9) begin
        // noise: loads at any index in any order, mixed with draws
        repeat ($urandom_range(8, 24)) begin
          if ($urandom_range(0, 2) == 0)
            queue_draw();
          else
            queue_load($urandom_range(0, NUM_ENTRIES - 1), rand_weight());
        end
      end else begin
        // pile-up: repeated max weights without a restart drive the running
        // sum into saturation
        queue_load(0, '1);
        repeat (70) queue_load($urandom_range(1, NUM_ENTRIES - 1), '1);
        repeat (4) queue_draw();
      end
      phase_no++;
    end

    settle();
    hit_cnt = 0;
    foreach (picks_hit[i]) hit_cnt += picks_hit[i];
    $display("Ran %0d loads and %0d draws across %0d register writes and %0d phases;",
             loads_seen, draws_seen, cfg_writes, phase_no);
    $display("%0d of %0d indices were picked at least once, %0d mismatches.",
             hit_cnt, NUM_ENTRIES, err_count);
    if (err_count == 0)
      $display("weighted_random_index_sampler test passed");
    else
      $display("weighted_random_index_sampler test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wris_pkg.sv
rtl/wris_ram.sv
rtl/wris_front.sv
rtl/wris_back.sv
rtl/weighted_random_index_sampler.sv
tb/sv/tb.sv
